@@ design/frpp_pkg.sv @@
// ----------------------------------------------------------------------------
// frpp_pkg
// Shared types, constants and boundary functions for the flash region page
// pointer ring.
// ----------------------------------------------------------------------------
package frpp_pkg;

  localparam int BLK_W      = 10;  // block number width
  localparam int END_W      = 11;  // region end register width
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int OP_W       = 2;
  localparam int SEL_W      = 2;   // region select field width
  localparam int IN_TDATA_W = 8;

  localparam int PAGES_PER_BLOCK_DEF = 64;
  localparam int REGIONS_DEF         = 3;

  localparam logic [END_W-1:0] REGION0_END_RST = END_W'(341);
  localparam logic [END_W-1:0] REGION1_END_RST = END_W'(682);
  localparam logic [END_W-1:0] REGION2_END_RST = END_W'(1024);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_REGION0_END = 2'd0;
  localparam logic [1:0] REG_REGION1_END = 2'd1;
  localparam logic [1:0] REG_REGION2_END = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADV_WRITE = 2'd0,
    OP_ADV_READ  = 2'd1,
    OP_QUERY     = 2'd2,
    OP_RESET_ALL = 2'd3
  } op_t;

  typedef struct packed {
    logic [END_W-1:0] region0_end;
    logic [END_W-1:0] region1_end;
    logic [END_W-1:0] region2_end;
  } cfg_t;

  // Region 0 starts at block 0; each later region starts where the one
  // before it ends. Regions past the third share the third one's bounds.
  function automatic logic [BLK_W-1:0] region_start(input int r, input cfg_t c);
    logic [BLK_W-1:0] s;
    if (r == 0) begin
      s = '0;
    end else if (r == 1) begin
      s = c.region0_end[BLK_W-1:0];
    end else begin
      s = c.region1_end[BLK_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [END_W-1:0] region_end(input int r, input cfg_t c);
    logic [END_W-1:0] e;
    if (r == 0) begin
      e = c.region0_end;
    end else if (r == 1) begin
      e = c.region1_end;
    end else begin
      e = c.region2_end;
    end
    return e;
  endfunction

  function automatic cfg_t cfg_reset_value();
    cfg_t c;
    c.region0_end = REGION0_END_RST;
    c.region1_end = REGION1_END_RST;
    c.region2_end = REGION2_END_RST;
    return c;
  endfunction

endpackage

@@ design/frpp_cfg.sv @@
// ----------------------------------------------------------------------------
// frpp_cfg
// APB-style register file holding the three region end blocks.
// ----------------------------------------------------------------------------
module frpp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [frpp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [frpp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [frpp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output frpp_pkg::cfg_t                   cfg_o
);

  frpp_pkg::cfg_t   cfg_r;
  logic [1:0]       reg_idx;
  logic             wr_en;
  logic [frpp_pkg::END_W-1:0] wdata;
  logic [frpp_pkg::END_W-1:0] rdata;

  assign reg_idx    = cfg_paddr[frpp_pkg::CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wdata      = cfg_pwdata[frpp_pkg::END_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= frpp_pkg::cfg_reset_value();
    end else if (wr_en) begin
      unique case (reg_idx)
        frpp_pkg::REG_REGION0_END: cfg_r.region0_end <= wdata;
        frpp_pkg::REG_REGION1_END: cfg_r.region1_end <= wdata;
        frpp_pkg::REG_REGION2_END: cfg_r.region2_end <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      frpp_pkg::REG_REGION0_END: rdata = cfg_r.region0_end;
      frpp_pkg::REG_REGION1_END: rdata = cfg_r.region1_end;
      frpp_pkg::REG_REGION2_END: rdata = cfg_r.region2_end;
      default:                   rdata = '0;
    endcase
  end

  assign cfg_prdata = frpp_pkg::CFG_DATA_W'(rdata);
  assign cfg_o      = cfg_r;

endmodule

@@ design/frpp_ring.sv @@
// ----------------------------------------------------------------------------
// frpp_ring
// Per-region write and read pointers with the single-step advance logic.
// ----------------------------------------------------------------------------
module frpp_ring #(
  parameter int PAGES_PER_BLOCK = frpp_pkg::PAGES_PER_BLOCK_DEF,
  parameter int REGIONS         = frpp_pkg::REGIONS_DEF,
  localparam int PAGE_W  = $clog2(PAGES_PER_BLOCK),
  localparam int RIDX_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  frpp_pkg::op_t                op,
  input  logic [frpp_pkg::SEL_W-1:0]   region,
  input  frpp_pkg::cfg_t               cfg,
  output logic [frpp_pkg::BLK_W-1:0]   write_block,
  output logic [PAGE_W-1:0]            write_page,
  output logic [frpp_pkg::BLK_W-1:0]   read_block,
  output logic [PAGE_W-1:0]            read_page,
  output logic                         region_caught_up,
  output logic                         all_caught_up,
  output logic                         erase_request,
  output logic [frpp_pkg::BLK_W-1:0]   erase_block
);

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES_PER_BLOCK - 1);

  logic [frpp_pkg::BLK_W-1:0] wblk_r [REGIONS];
  logic [PAGE_W-1:0]          wpg_r  [REGIONS];
  logic [frpp_pkg::BLK_W-1:0] rblk_r [REGIONS];
  logic [PAGE_W-1:0]          rpg_r  [REGIONS];
  logic [frpp_pkg::BLK_W-1:0] wblk_nxt [REGIONS];
  logic [PAGE_W-1:0]          wpg_nxt  [REGIONS];
  logic [frpp_pkg::BLK_W-1:0] rblk_nxt [REGIONS];
  logic [PAGE_W-1:0]          rpg_nxt  [REGIONS];

  logic                       sel_ok;
  logic [RIDX_W-1:0]          ridx;
  logic                       w_wrap;
  logic                       r_wrap;
  logic [frpp_pkg::BLK_W-1:0] w_blk_adv;
  logic [frpp_pkg::BLK_W-1:0] r_blk_adv;
  logic [frpp_pkg::BLK_W-1:0] w_blk_cur;
  logic [frpp_pkg::BLK_W-1:0] r_blk_cur;
  logic [PAGE_W-1:0]          w_pg_cur;
  logic [PAGE_W-1:0]          r_pg_cur;
  logic [frpp_pkg::BLK_W-1:0] start_sel;
  logic [frpp_pkg::END_W-1:0] end_sel;
  logic                       do_write;
  logic                       do_read;

  // Next block in the ring: at or past the end it goes back to the start.
  function automatic logic [frpp_pkg::BLK_W-1:0] next_block(
    input logic [frpp_pkg::BLK_W-1:0] blk,
    input logic [frpp_pkg::END_W-1:0] rend,
    input logic [frpp_pkg::BLK_W-1:0] rstart
  );
    logic [frpp_pkg::END_W-1:0] nb;
    nb = frpp_pkg::END_W'(blk) + frpp_pkg::END_W'(1);
    return (nb >= rend) ? rstart : nb[frpp_pkg::BLK_W-1:0];
  endfunction

  assign sel_ok = (int'(region) < REGIONS);
  assign ridx   = RIDX_W'(region);

  always_comb begin
    start_sel = '0;
    end_sel   = '0;
    for (int r = 0; r < REGIONS; r++) begin
      if (ridx == RIDX_W'(r)) begin
        start_sel = frpp_pkg::region_start(r, cfg);
        end_sel   = frpp_pkg::region_end(r, cfg);
      end
    end
  end

  assign w_blk_cur = wblk_r[ridx];
  assign w_pg_cur  = wpg_r[ridx];
  assign r_blk_cur = rblk_r[ridx];
  assign r_pg_cur  = rpg_r[ridx];

  assign w_wrap    = (w_pg_cur >= LAST_PAGE);
  assign r_wrap    = (r_pg_cur >= LAST_PAGE);
  assign w_blk_adv = next_block(w_blk_cur, end_sel, start_sel);
  assign r_blk_adv = next_block(r_blk_cur, end_sel, start_sel);
  assign do_write  = sel_ok && (op == frpp_pkg::OP_ADV_WRITE);
  assign do_read   = sel_ok && (op == frpp_pkg::OP_ADV_READ);

  always_comb begin
    for (int r = 0; r < REGIONS; r++) begin
      wblk_nxt[r] = wblk_r[r];
      wpg_nxt[r]  = wpg_r[r];
      rblk_nxt[r] = rblk_r[r];
      rpg_nxt[r]  = rpg_r[r];
      if (op == frpp_pkg::OP_RESET_ALL) begin
        wblk_nxt[r] = frpp_pkg::region_start(r, cfg);
        wpg_nxt[r]  = '0;
        rblk_nxt[r] = frpp_pkg::region_start(r, cfg);
        rpg_nxt[r]  = '0;
      end else if (ridx == RIDX_W'(r)) begin
        if (do_write) begin
          wblk_nxt[r] = w_wrap ? w_blk_adv : w_blk_cur;
          wpg_nxt[r]  = w_wrap ? '0 : w_pg_cur + PAGE_W'(1);
        end
        if (do_read) begin
          rblk_nxt[r] = r_wrap ? r_blk_adv : r_blk_cur;
          rpg_nxt[r]  = r_wrap ? '0 : r_pg_cur + PAGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REGIONS; r++) begin
        wblk_r[r] <= frpp_pkg::region_start(r, frpp_pkg::cfg_reset_value());
        wpg_r[r]  <= '0;
        rblk_r[r] <= frpp_pkg::region_start(r, frpp_pkg::cfg_reset_value());
        rpg_r[r]  <= '0;
      end
    end else if (step_en) begin
      for (int r = 0; r < REGIONS; r++) begin
        wblk_r[r] <= wblk_nxt[r];
        wpg_r[r]  <= wpg_nxt[r];
        rblk_r[r] <= rblk_nxt[r];
        rpg_r[r]  <= rpg_nxt[r];
      end
    end
  end

  always_comb begin
    all_caught_up = 1'b1;
    for (int r = 0; r < REGIONS; r++) begin
      if (wblk_nxt[r] != rblk_nxt[r] || wpg_nxt[r] != rpg_nxt[r]) begin
        all_caught_up = 1'b0;
      end
    end
  end

  always_comb begin
    if (sel_ok) begin
      write_block      = wblk_nxt[ridx];
      write_page       = wpg_nxt[ridx];
      read_block       = rblk_nxt[ridx];
      read_page        = rpg_nxt[ridx];
      region_caught_up = (wblk_nxt[ridx] == rblk_nxt[ridx]) &&
                         (wpg_nxt[ridx] == rpg_nxt[ridx]);
    end else begin
      write_block      = '0;
      write_page       = '0;
      read_block       = '0;
      read_page        = '0;
      region_caught_up = 1'b0;
    end
  end

  // Only a write advance that steps past the last page into a new block
  // asks for an erase.
  assign erase_request = do_write && w_wrap;
  assign erase_block   = erase_request ? w_blk_adv : '0;

endmodule

@@ design/flash_region_page_pointer_ring.sv @@
// ----------------------------------------------------------------------------
// flash_region_page_pointer_ring
// Circular-buffer write and read page pointers for several flash regions.
// ----------------------------------------------------------------------------
// Each request (operation, region) is captured in an input register, stepped
// through the pointer logic once the result register is free and held in a
// result register until the consumer takes it. One request per cycle is
// sustained while out_tready stays high. The result is registered twice:
// the input register loads at the accepting edge, and the result register
// loads after it around a single step of the pointer update. The region
// end registers may be rewritten at any idle time, but pointers pick up new
// region starts on a reset-all request or when they wrap past a region end.
module flash_region_page_pointer_ring #(
  parameter int PAGES_PER_BLOCK = frpp_pkg::PAGES_PER_BLOCK_DEF,
  parameter int REGIONS         = frpp_pkg::REGIONS_DEF,
  localparam int PAGE_W    = $clog2(PAGES_PER_BLOCK),
  localparam int DATA_BITS = 3 * frpp_pkg::BLK_W + 2 * PAGE_W + 3,
  localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8,
  localparam int PAD_W     = TDATA_W - DATA_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // operation [1:0]
  input  logic [frpp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // region [1:0]
  input  logic [frpp_pkg::SEL_W-1:0]       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // write_block, write_page, read_block, read_page, region_caught_up,
  // all_caught_up, erase_request, erase_block, zero fill
  output logic [TDATA_W-1:0]               out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [frpp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [frpp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [frpp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  frpp_pkg::cfg_t              cfg;
  logic                        in_vld_r;
  frpp_pkg::op_t               op_r;
  logic [frpp_pkg::SEL_W-1:0]  region_r;
  logic                        out_vld_r;
  logic [DATA_BITS-1:0]        res_r;
  logic                        load_out;

  logic [frpp_pkg::BLK_W-1:0]  write_block;
  logic [PAGE_W-1:0]           write_page;
  logic [frpp_pkg::BLK_W-1:0]  read_block;
  logic [PAGE_W-1:0]           read_page;
  logic                        region_caught_up;
  logic                        all_caught_up;
  logic                        erase_request;
  logic [frpp_pkg::BLK_W-1:0]  erase_block;

  frpp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // The captured request moves on whenever the result register is free
  // or being emptied in the same cycle.
  assign load_out  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (load_out) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= frpp_pkg::op_t'(in_tdata[frpp_pkg::OP_W-1:0]);
      region_r <= in_tuser;
    end
  end

  frpp_ring #(
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
    .REGIONS         (REGIONS)
  ) u_ring (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (load_out),
    .op               (op_r),
    .region           (region_r),
    .cfg              (cfg),
    .write_block      (write_block),
    .write_page       (write_page),
    .read_block       (read_block),
    .read_page        (read_page),
    .region_caught_up (region_caught_up),
    .all_caught_up    (all_caught_up),
    .erase_request    (erase_request),
    .erase_block      (erase_block)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r <= {erase_block, erase_request, all_caught_up, region_caught_up,
                read_page, read_block, write_page, write_block};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, res_r};

endmodule
